// ===== design/olve_pkg.sv =====
package olve_pkg;

   // command codes
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_FIND       = 3'd4;
   localparam logic [2:0] CMD_REMOVE     = 3'd5;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic [3:0]         position;
      logic signed [31:0] popped_value;
      logic [4:0]         entries_held;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_POP,
      ST_FIND,
      ST_RM_HEAD,
      ST_RM_TAIL,
      ST_RM_SCAN,
      ST_SHIFT,
      ST_RESP
   } state_type;

endpackage

// ===== design/olve_mem.sv =====
module olve_mem #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/olve_ctrl.sv =====
module olve_ctrl #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  olve_pkg::req_payload_type     req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output olve_pkg::rsp_payload_type     rsp_data,
   output logic                          mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]      mem_wr_addr,
   output logic [DATA_WIDTH-1:0]         mem_wr_data,
   output logic [$clog2(DEPTH)-1:0]      mem_rd_addr,
   input  logic [DATA_WIDTH-1:0]         mem_rd_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   olve_pkg::state_type       state_ff, state_in;
   logic [IW-1:0]             front_ff, front_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             scan_ff, scan_in;
   logic [2:0]                cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0]     val_ff, val_in;
   olve_pkg::rsp_payload_type res_ff, res_in;
   olve_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH+31:0]    val_ext;
   logic                      full;
   logic                      empty;
   logic                      hit;

   // ring slot of a position counted from the front
   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] front,
                                            input logic [CW-1:0] pos);
      logic [CW:0] sum;
      sum = (CW+1)'(front) + (CW+1)'(pos);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   function automatic logic [3:0] pos_field(input logic [CW-1:0] pos);
      logic [CW+3:0] wide;
      wide = {4'b0, pos};
      return wide[3:0];
   endfunction

   function automatic logic [31:0] data_field(input logic [DATA_WIDTH-1:0] d);
      logic [DATA_WIDTH+31:0] wide;
      wide = {32'b0, d};
      return wide[31:0];
   endfunction

   function automatic logic [4:0] count_field(input logic [CW-1:0] c);
      logic [CW+4:0] wide;
      wide = {5'b0, c};
      return wide[4:0];
   endfunction

   assign val_ext   = (DATA_WIDTH+32)'(req_data.value);
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign hit       = (mem_rd_data == val_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olve_pkg::ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      cmd_ff  <= cmd_in;
      val_ff  <= val_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = slot_of(front_ff, count_ff);
      mem_wr_data  = val_ff;
      mem_rd_addr  = front_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         olve_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               val_in   = val_ext[DATA_WIDTH-1:0];
               state_in = olve_pkg::ST_START;
            end
         end

         olve_pkg::ST_START: begin
            res_in   = '0;
            state_in = olve_pkg::ST_RESP;
            unique case (cmd_ff) inside
               olve_pkg::CMD_PUSH_BACK, olve_pkg::CMD_PUSH_FRONT: begin
                  if (full) begin
                     res_in.status = olve_pkg::STATUS_FULL;
                  end else begin
                     mem_wr_en = 1'b1;
                     if (cmd_ff == olve_pkg::CMD_PUSH_FRONT) begin
                        front_in    = (front_ff == '0) ? IW'(DEPTH - 1)
                                                       : front_ff - IW'(1);
                        mem_wr_addr = front_in;
                     end
                     count_in = count_ff + CW'(1);
                  end
               end
               olve_pkg::CMD_POP_FRONT, olve_pkg::CMD_POP_BACK: begin
                  if (empty) begin
                     res_in.status = olve_pkg::STATUS_EMPTY;
                  end else begin
                     if (cmd_ff == olve_pkg::CMD_POP_BACK) begin
                        mem_rd_addr = slot_of(front_ff, count_ff - CW'(1));
                     end
                     state_in = olve_pkg::ST_POP;
                  end
               end
               olve_pkg::CMD_FIND: begin
                  if (empty) begin
                     res_in.status = olve_pkg::STATUS_EMPTY;
                  end else begin
                     scan_in  = '0;
                     state_in = olve_pkg::ST_FIND;
                  end
               end
               olve_pkg::CMD_REMOVE: begin
                  if (empty) begin
                     res_in.status = olve_pkg::STATUS_EMPTY;
                  end else begin
                     state_in = olve_pkg::ST_RM_HEAD;
                  end
               end
               default: begin
               end
            endcase
         end

         olve_pkg::ST_POP: begin
            res_in.popped_value = data_field(mem_rd_data);
            count_in            = count_ff - CW'(1);
            if (cmd_ff == olve_pkg::CMD_POP_FRONT) begin
               front_in = (front_ff == IW'(DEPTH - 1)) ? '0 : front_ff + IW'(1);
            end
            state_in = olve_pkg::ST_RESP;
         end

         // one entry compared per cycle, next read issued alongside
         olve_pkg::ST_FIND: begin
            if (hit) begin
               res_in.found    = 1'b1;
               res_in.position = pos_field(scan_ff);
               state_in        = olve_pkg::ST_RESP;
            end else if (scan_ff == count_ff - CW'(1)) begin
               res_in.status = olve_pkg::STATUS_NOT_FOUND;
               state_in      = olve_pkg::ST_RESP;
            end else begin
               scan_in     = scan_ff + CW'(1);
               mem_rd_addr = slot_of(front_ff, scan_in);
            end
         end

         olve_pkg::ST_RM_HEAD: begin
            if (hit) begin
               front_in = (front_ff == IW'(DEPTH - 1)) ? '0 : front_ff + IW'(1);
               count_in            = count_ff - CW'(1);
               res_in.found        = 1'b1;
               res_in.popped_value = data_field(val_ff);
               state_in            = olve_pkg::ST_RESP;
            end else begin
               mem_rd_addr = slot_of(front_ff, count_ff - CW'(1));
               state_in    = olve_pkg::ST_RM_TAIL;
            end
         end

         olve_pkg::ST_RM_TAIL: begin
            if (hit) begin
               count_in            = count_ff - CW'(1);
               res_in.found        = 1'b1;
               res_in.position     = pos_field(count_ff - CW'(1));
               res_in.popped_value = data_field(val_ff);
               state_in            = olve_pkg::ST_RESP;
            end else if (count_ff < CW'(3)) begin
               res_in.status = olve_pkg::STATUS_NOT_FOUND;
               state_in      = olve_pkg::ST_RESP;
            end else begin
               scan_in     = CW'(1);
               mem_rd_addr = slot_of(front_ff, CW'(1));
               state_in    = olve_pkg::ST_RM_SCAN;
            end
         end

         // middle entries only, front and back already checked
         olve_pkg::ST_RM_SCAN: begin
            if (hit) begin
               res_in.found        = 1'b1;
               res_in.position     = pos_field(scan_ff);
               res_in.popped_value = data_field(val_ff);
               mem_rd_addr         = slot_of(front_ff, scan_ff + CW'(1));
               state_in            = olve_pkg::ST_SHIFT;
            end else if ((CW+1)'(scan_ff) + (CW+1)'(2) >= (CW+1)'(count_ff)) begin
               res_in.status = olve_pkg::STATUS_NOT_FOUND;
               state_in      = olve_pkg::ST_RESP;
            end else begin
               scan_in     = scan_ff + CW'(1);
               mem_rd_addr = slot_of(front_ff, scan_in);
            end
         end

         // move entry k+1 into slot k, read of k+2 overlaps the write
         olve_pkg::ST_SHIFT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot_of(front_ff, scan_ff);
            mem_wr_data = mem_rd_data;
            if ((CW+1)'(scan_ff) + (CW+1)'(2) < (CW+1)'(count_ff)) begin
               scan_in     = scan_ff + CW'(1);
               mem_rd_addr = slot_of(front_ff, scan_ff + CW'(2));
            end else begin
               count_in = count_ff - CW'(1);
               state_in = olve_pkg::ST_RESP;
            end
         end

         olve_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in              = res_ff;
               rsp_in.entries_held = count_field(count_ff);
               rsp_valid_in        = 1'b1;
               state_in            = olve_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = olve_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/ordered_value_list_engine.sv =====
// accept to response: push and unused codes go from START straight to RESP, pop
//   passes POP, find compares entries from the front until a hit or the back, and
//   remove tries head, tail, then middle entries, shifting later ones to close the gap
// throughput: one transaction at a time, set by the single-read-port entry memory
//   scanned one entry per cycle; a waiting response does not block the next request
// reset: synchronous active high, empties the list and drops any pending response
module ordered_value_list_engine #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  olve_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output olve_pkg::rsp_payload_type rsp_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   // entry memory port, written by the sequencer only
   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   // sequencer: ring front/count, scan and shift walk, response register.
   // a write and the next read never hit the same entry in one cycle, so
   // no forwarding is needed around the memory
   olve_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // ring storage, one write and one registered read per cycle
   olve_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   // list geometry of the default build
   localparam int LIST_DEPTH = 16;

   // codes that the block must ignore
   localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

   // run limits; the first two in clock cycles, the last in commands
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 64;
   localparam int RANDOM_ITEMS = 1400;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   olve_pkg::req_payload_type req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   olve_pkg::rsp_payload_type rsp_data;

   // shadow copy of the list, advanced once per accepted request
   logic signed [31:0] list_slots [LIST_DEPTH];
   logic [3:0]         list_front = '0;
   int unsigned        list_count = 0;

   // responses still owed by the block, oldest first
   olve_pkg::rsp_payload_type pending_responses [$];

   int  mismatches     = 0;
   int  commands_sent  = 0;
   int  status_tally [4] = '{default: 0};
   int  cycle_count    = 0;
   bit  quiet_sender   = 1'b0;
   bit  quiet_receiver = 1'b0;

   ordered_value_list_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ring slot of the entry at a given distance from the front
   function automatic logic [3:0] slot_at(input int unsigned pos);
      return 4'(list_front + pos);
   endfunction

   // expected response for one command, updating the shadow list as the block should
   function automatic olve_pkg::rsp_payload_type predict_list_response(
         input olve_pkg::req_payload_type item);
      olve_pkg::rsp_payload_type result;
      logic signed [31:0]        key;
      int unsigned               i;
      int unsigned               k;
      logic                      hit;
      result = '0;
      key    = item.value;
      hit    = 1'b0;
      case (item.cmd)
         olve_pkg::CMD_PUSH_BACK, olve_pkg::CMD_PUSH_FRONT: begin
            if (list_count == LIST_DEPTH) begin
               result.status = olve_pkg::STATUS_FULL;
            end else begin
               if (item.cmd == olve_pkg::CMD_PUSH_BACK) begin
                  list_slots[slot_at(list_count)] = key;
               end else begin
                  list_front             = list_front - 4'd1;
                  list_slots[list_front] = key;
               end
               list_count++;
            end
         end
         olve_pkg::CMD_POP_FRONT, olve_pkg::CMD_POP_BACK: begin
            if (list_count == 0) begin
               result.status = olve_pkg::STATUS_EMPTY;
            end else if (item.cmd == olve_pkg::CMD_POP_FRONT) begin
               result.popped_value = list_slots[list_front];
               list_front          = list_front + 4'd1;
               list_count--;
            end else begin
               result.popped_value = list_slots[slot_at(list_count - 1)];
               list_count--;
            end
         end
         olve_pkg::CMD_FIND: begin
            if (list_count == 0) begin
               result.status = olve_pkg::STATUS_EMPTY;
            end else begin
               for (i = 0; i < list_count && !hit; i++) begin
                  if (list_slots[slot_at(i)] == key) begin
                     hit             = 1'b1;
                     result.found    = 1'b1;
                     result.position = 4'(i);
                  end
               end
               if (!hit) result.status = olve_pkg::STATUS_NOT_FOUND;
            end
         end
         olve_pkg::CMD_REMOVE: begin
            if (list_count == 0) begin
               result.status = olve_pkg::STATUS_EMPTY;
            end else if (list_slots[list_front] == key) begin
               // head match wins over any other
               list_front          = list_front + 4'd1;
               list_count--;
               result.found        = 1'b1;
               result.popped_value = key;
            end else if (list_slots[slot_at(list_count - 1)] == key) begin
               // then the tail
               result.position     = 4'(list_count - 1);
               list_count--;
               result.found        = 1'b1;
               result.popped_value = key;
            end else begin
               // first match in the middle, later entries close the gap
               for (i = 1; i + 1 < list_count && !hit; i++) begin
                  if (list_slots[slot_at(i)] == key) begin
                     hit = 1'b1;
                     for (k = i; k + 1 < list_count; k++)
                        list_slots[slot_at(k)] = list_slots[slot_at(k + 1)];
                     list_count--;
                     result.found        = 1'b1;
                     result.position     = 4'(i);
                     result.popped_value = key;
                  end
               end
               if (!hit) result.status = olve_pkg::STATUS_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
      result.entries_held = 5'(list_count);
      return result;
   endfunction

   // operand mix: a value already held in 45 of 100 draws, so find and remove hit at every position
   function automatic logic signed [31:0] choose_operand();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45 && list_count > 0)
         return list_slots[slot_at($urandom_range(0, list_count - 1))];
      else if (r < 70)
         return int'($urandom_range(0, 8)) - 4;
      else if (r < 75)
         return r[0] ? VALUE_MAX : VALUE_MIN;
      else
         return $urandom;
   endfunction

   // one request transaction; called and returns at a falling edge
   task automatic issue_command(input logic [2:0] op, input logic signed [31:0] operand);
      int                        gap;
      olve_pkg::req_payload_type item;
      item.cmd   = op;
      item.value = operand;
      gap = quiet_sender ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pending_responses.push_back(predict_list_response(item));
      commands_sent++;
      @(negedge clock);
      // occasionally switch between gappy and back-to-back traffic
      if ($urandom_range(0, 59) == 0) quiet_sender = !quiet_sender;
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // response side: random stalls before each transaction
   initial begin : response_sink
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = quiet_receiver ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
         if ($urandom_range(0, 59) == 0) quiet_receiver = !quiet_receiver;
      end
   end

   // compare every accepted response against the oldest prediction
   always @(posedge clock) begin : response_check
      olve_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            $error("response with no command outstanding: %p", rsp_data);
            mismatches++;
         end else begin
            want = pending_responses.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("found", want.found, rsp_data.found);
            check_field("position", want.position, rsp_data.position);
            check_field("popped_value", want.popped_value, rsp_data.popped_value);
            check_field("entries_held", want.entries_held, rsp_data.entries_held);
            status_tally[rsp_data.status]++;
         end
      end
   end

   // everything that touches an empty list, plus the ignored codes
   task automatic test_empty_list;
      issue_command(olve_pkg::CMD_POP_FRONT, VALUE_MAX);
      issue_command(olve_pkg::CMD_POP_BACK, VALUE_MIN);
      issue_command(olve_pkg::CMD_FIND, 32'sd0);
      issue_command(olve_pkg::CMD_REMOVE, -32'sd1);
      issue_command(CMD_UNUSED_6, 32'sd17);
      issue_command(CMD_UNUSED_7, -32'sd17);
   endtask

   // extreme values at both ends, then remove at head, tail and middle
   task automatic test_extremes_and_remove;
      issue_command(olve_pkg::CMD_PUSH_BACK, VALUE_MAX);
      issue_command(olve_pkg::CMD_PUSH_FRONT, VALUE_MIN);
      issue_command(olve_pkg::CMD_PUSH_BACK, 32'sd0);
      issue_command(olve_pkg::CMD_PUSH_BACK, -32'sd1);
      issue_command(olve_pkg::CMD_PUSH_FRONT, 32'sd5);
      issue_command(olve_pkg::CMD_FIND, -32'sd1);
      issue_command(olve_pkg::CMD_FIND, 32'sd12345);
      issue_command(olve_pkg::CMD_REMOVE, 32'sd5);
      issue_command(olve_pkg::CMD_REMOVE, -32'sd1);
      issue_command(olve_pkg::CMD_PUSH_BACK, 32'sd7);
      issue_command(olve_pkg::CMD_REMOVE, VALUE_MAX);
      issue_command(olve_pkg::CMD_REMOVE, 32'sd99);
      issue_command(olve_pkg::CMD_POP_FRONT, 32'sd0);
      issue_command(olve_pkg::CMD_POP_BACK, 32'sd0);
      issue_command(CMD_UNUSED_6, VALUE_MIN);
   endtask

   // fill to the brim, push into a full list, find and remove, then drain to empty
   task automatic test_full_list;
      int i;
      i = 0;
      while (list_count < LIST_DEPTH) begin
         issue_command(i[0] ? olve_pkg::CMD_PUSH_FRONT : olve_pkg::CMD_PUSH_BACK, $urandom);
         i++;
      end
      issue_command(olve_pkg::CMD_PUSH_BACK, VALUE_MAX);
      issue_command(olve_pkg::CMD_PUSH_FRONT, VALUE_MIN);
      issue_command(olve_pkg::CMD_FIND, list_slots[slot_at(LIST_DEPTH - 1)]);
      issue_command(olve_pkg::CMD_REMOVE, list_slots[slot_at(8)]);
      issue_command(olve_pkg::CMD_REMOVE, list_slots[slot_at(list_count - 1)]);
      issue_command(olve_pkg::CMD_REMOVE, list_slots[list_front]);
      issue_command(olve_pkg::CMD_FIND, list_slots[slot_at(1)] + 32'sd1);
      i = 0;
      while (list_count > 0) begin
         issue_command(i[0] ? olve_pkg::CMD_POP_BACK : olve_pkg::CMD_POP_FRONT, $urandom);
         i++;
      end
   endtask

   // random traffic in phases that grow, shrink or hold the list size
   task automatic test_random_traffic(input int total);
      int         n;
      int         r;
      int         push_pct;
      logic [2:0] op;
      push_pct = 30;
      for (n = 0; n < total; n++) begin
         if (n % 80 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 55;
               1:       push_pct = 15;
               default: push_pct = 30;
            endcase
         end
         r = $urandom_range(0, 99);
         if (r < 2)
            op = $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
         else if (r < push_pct)
            op = $urandom_range(0, 1) ? olve_pkg::CMD_PUSH_FRONT : olve_pkg::CMD_PUSH_BACK;
         else if (r < push_pct + 20)
            op = $urandom_range(0, 1) ? olve_pkg::CMD_POP_FRONT : olve_pkg::CMD_POP_BACK;
         else if (r < push_pct + 35)
            op = olve_pkg::CMD_FIND;
         else
            op = olve_pkg::CMD_REMOVE;
         issue_command(op, choose_operand());
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_extremes_and_remove();
      test_full_list();
      test_random_traffic(RANDOM_ITEMS);

      req_valid <= 1'b0;
      // wait out outstanding responses, then watch for strays
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d commands sent; responses: %0d ok, %0d empty, %0d full, %0d not found",
               commands_sent, status_tally[olve_pkg::STATUS_OK],
               status_tally[olve_pkg::STATUS_EMPTY], status_tally[olve_pkg::STATUS_FULL],
               status_tally[olve_pkg::STATUS_NOT_FOUND]);
      $display("%0d field mismatches in %0d cycles", mismatches, cycle_count);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
